// ===== src/cct_pkg.sv =====
// Shared types, codes and helpers of the call context outcome tracker.
// Used by all modules but cct_ram and by the checker; depends on nothing.
package cct_pkg;

	localparam int SLOTS_DEF = 64;
	// Depth of the command queue between front and back; a power of two.
	localparam int QDEPTH = 2;

	localparam logic [1:0] KIND_DISPATCH = 2'd0;
	localparam logic [1:0] KIND_STATE    = 2'd1;
	localparam logic [1:0] KIND_TSX      = 2'd2;
	localparam logic [1:0] KIND_EXPIRY   = 2'd3;

	localparam logic [2:0] CS_EARLY        = 3'd1;
	localparam logic [2:0] CS_CONNECTING   = 3'd2;
	localparam logic [2:0] CS_CONFIRMED    = 3'd3;
	localparam logic [2:0] CS_DISCONNECTED = 3'd4;

	localparam logic [1:0] RK_REPORT = 2'd0;
	localparam logic [1:0] RK_HANGUP = 2'd1;
	localparam logic [1:0] RK_ACCEPT = 2'd2;

	localparam logic [1:0] TMR_NONE = 2'd0;
	localparam logic [1:0] TMR_MAIN = 2'd1;
	localparam logic [1:0] TMR_RING = 2'd2;

	localparam logic [3:0] OC_MISSED      = 4'd0;
	localparam logic [3:0] OC_UNREACHABLE = 4'd1;
	localparam logic [3:0] OC_NO_ANSWER   = 4'd2;
	localparam logic [3:0] OC_BUSY        = 4'd3;
	localparam logic [3:0] OC_REJECTED    = 4'd4;
	localparam logic [3:0] OC_UNAVAILABLE = 4'd5;
	localparam logic [3:0] OC_NET_DOWN    = 4'd6;
	localparam logic [3:0] OC_CF_MCA      = 4'd7;
	localparam logic [3:0] OC_CF_NUMBER   = 4'd8;
	localparam logic [3:0] OC_UNKNOWN     = 4'd9;

	localparam logic [9:0] ST_OK          = 10'd200;
	localparam logic [9:0] ST_RINGING     = 10'd180;
	localparam logic [9:0] ST_FORWARDED   = 10'd181;
	localparam logic [9:0] ST_MOVED       = 10'd302;
	localparam logic [9:0] ST_TIMEOUT     = 10'd408;
	localparam logic [9:0] ST_UNAVAILABLE = 10'd480;
	localparam logic [9:0] ST_BUSY_HERE   = 10'd486;
	localparam logic [9:0] ST_TERMINATED  = 10'd487;
	localparam logic [9:0] ST_BUSY_ALL    = 10'd600;
	localparam logic [9:0] ST_DECLINE     = 10'd603;
	localparam logic [9:0] ST_SVC_DOWN    = 10'd503;
	localparam logic [9:0] ST_GW_TIMEOUT  = 10'd504;

	typedef struct packed {
		logic [1:0]  kind;
		logic [11:0] call_id;
		logic [31:0] request_tag;
		logic [31:0] time_ms;
		logic        make_ok;
		logic [2:0]  call_state;
		logic [9:0]  sip_status;
		logic        tsx_completed;
		logic        tsx_is_uac;
		logic        tsx_is_prack;
		logic [5:0]  slot;
		logic        timer_which;
	} item_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [11:0] out_call_id;
		logic [31:0] out_tag;
		logic [5:0]  out_slot;
		logic [3:0]  outcome;
		logic [9:0]  final_status;
		logic [31:0] elapsed_ms;
	} result_t;

	// Classified operation handed from the front to the back.
	typedef enum logic [3:0] {
		OP_NOP,
		OP_DISPATCH,
		OP_RING,
		OP_DISARM,
		OP_CONFIRM,
		OP_DISCONNECT,
		OP_FORWARD,
		OP_PRACK_OK,
		OP_EXPIRE
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [11:0] call_id;
		logic [31:0] tag;
		logic [31:0] time_ms;
		logic        make_ok;
		logic [9:0]  status;
		logic [5:0]  slot;
		logic        which;
	} cmd_t;

	// Per-slot record held in the slot memory.
	typedef struct packed {
		logic [11:0] call_id;
		logic [31:0] tag;
		logic [31:0] start;
		logic        ringing;
		logic        cancelled;
		logic [1:0]  timer;
	} slot_rec_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_LOOK,
		BK_EXEC
	} bk_state_t;

	function automatic logic [3:0] outcome_of(input logic rg, input logic cx,
			input logic [9:0] st);
		logic [3:0] oc;
		if (cx && rg && st == ST_TERMINATED) oc = OC_MISSED;
		else if (cx && !rg && st == ST_TERMINATED) oc = OC_UNREACHABLE;
		else if (rg && (st == ST_TIMEOUT || st == ST_TERMINATED)) oc = OC_NO_ANSWER;
		else if (st == ST_BUSY_HERE || st == ST_BUSY_ALL) oc = OC_BUSY;
		else if (st == ST_DECLINE) oc = OC_REJECTED;
		else if (st == ST_UNAVAILABLE) oc = OC_UNAVAILABLE;
		else if (st == ST_TIMEOUT && !rg) oc = OC_UNREACHABLE;
		else if (st == ST_SVC_DOWN || st == ST_GW_TIMEOUT) oc = OC_NET_DOWN;
		else if (st == ST_OK) oc = OC_CF_MCA;
		else if (st == ST_FORWARDED || st == ST_MOVED) oc = OC_CF_NUMBER;
		else oc = OC_UNKNOWN;
		return oc;
	endfunction

endpackage

// ===== src/call_context_outcome_tracker.sv =====
// Top level of the call context outcome tracker: front end, command queue
// and back end. Depends on cct_pkg, cct_front, cct_queue and cct_back.
//
//   channel   handshake            payload
//   input     start, busy          item   (item_t)
//   output    done                 result (result_t)
//
// The back end takes each item through a lookup state (slot lookup with the
// memory read) and an execute state (update and result); it pops the next
// item only once it executes the last. done is high for one cycle per result.
// The two-entry queue lets the front take items while the back is working;
// busy is high only while that queue is full. Items that cannot change
// anything take no queue entry and give no result. Reset is asynchronous
// and leaves every slot free. The receiver cannot stall the block.
module call_context_outcome_tracker import cct_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  item_t   item,
	output logic    busy,
	output logic    done,
	output result_t result
);

	logic q_push, q_pop, q_empty, q_full;
	cmd_t q_wdata, q_rdata;

	cct_front u_front (
		.start  (start),
		.item   (item),
		.q_full (q_full),
		.busy   (busy),
		.push   (q_push),
		.cmd    (q_wdata)
	);

	cct_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty),
		.full   (q_full)
	);

	cct_back #(.SLOTS(SLOTS)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_data  (q_rdata),
		.q_empty (q_empty),
		.pop     (q_pop),
		.done    (done),
		.result  (result)
	);

endmodule

// ===== src/cct_ram.sv =====
// Generic single-write, single-read memory with a registered read port.
// No dependencies.
module cct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/cct_front.sv =====
// Front end: takes items and classifies them into back-end commands.
// Items that can change nothing are dropped here. Depends on cct_pkg.
module cct_front import cct_pkg::*; (
	input  logic  start,
	input  item_t item,
	input  logic  q_full,
	output logic  busy,
	output logic  push,
	output cmd_t  cmd
);

	op_t op;

	always_comb begin
		op = OP_NOP;
		unique case (item.kind)
			KIND_DISPATCH: op = OP_DISPATCH;
			KIND_STATE: begin
				unique case (item.call_state)
					CS_EARLY: begin
						if (item.sip_status == ST_RINGING) op = OP_RING;
					end
					CS_CONNECTING:   op = OP_DISARM;
					CS_CONFIRMED:    op = OP_CONFIRM;
					CS_DISCONNECTED: op = OP_DISCONNECT;
					default:         op = OP_NOP;
				endcase
			end
			KIND_TSX: begin
				if (item.tsx_completed) begin
					if (item.sip_status == ST_FORWARDED || item.sip_status == ST_MOVED) begin
						op = OP_FORWARD;
					end else if (item.tsx_is_uac && item.tsx_is_prack
							&& item.sip_status == ST_OK) begin
						op = OP_PRACK_OK;
					end
				end
			end
			KIND_EXPIRY: op = OP_EXPIRE;
			default:     op = OP_NOP;
		endcase
	end

	assign busy = q_full;
	assign push = start && !q_full && (op != OP_NOP);

	assign cmd.op      = op;
	assign cmd.call_id = item.call_id;
	assign cmd.tag     = item.request_tag;
	assign cmd.time_ms = item.time_ms;
	assign cmd.make_ok = item.make_ok;
	assign cmd.status  = item.sip_status;
	assign cmd.slot    = item.slot;
	assign cmd.which   = item.timer_which;

endmodule

// ===== src/cct_queue.sv =====
// Short command queue between the front and the back end.
// Depends on cct_pkg for the command type and its depth.
module cct_queue import cct_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wdata,
	input  logic pop,
	output cmd_t rdata,
	output logic empty,
	output logic full
);

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	cmd_t          mem_q [QDEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CW'(QDEPTH));
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + PW'(1);
			if (pop) rd_q <= rd_q + PW'(1);
			if (push && !pop) cnt_q <= cnt_q + CW'(1);
			else if (pop && !push) cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wdata;
	end

endmodule

// ===== src/cct_back.sv =====
// Back end: slot lookup, slot memory, free list and result generation.
// Depends on cct_pkg and cct_ram.
module cct_back import cct_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cmd_t    q_data,
	input  logic    q_empty,
	output logic    pop,
	output logic    done,
	output result_t result
);

	localparam int SW = $clog2(SLOTS);
	localparam int LW = $clog2(SLOTS + 1);
	localparam int RW = $bits(slot_rec_t);

	bk_state_t state_q, state_d;
	cmd_t      cur_s1;
	logic [SW-1:0] sel_s2;
	logic          hit_s2;

	logic [SLOTS-1:0] active_q;
	logic [SLOTS-1:0] link_vld_q;
	logic [11:0]      cam_q [SLOTS];
	logic [LW-1:0]    free_top_q, free_top_d;
	logic             done_q;
	result_t          result_q;

	logic          pool_full;
	logic [SW-1:0] top_idx;
	logic          cam_hit;
	logic [SW-1:0] cam_idx;
	logic          exp_in;
	logic [SW-1:0] exp_idx;
	logic [SW-1:0] look_sel;
	logic          look_hit;

	logic          exec_en;
	logic          rec_we;
	slot_rec_t     rec, upd;
	logic [RW-1:0] rec_rdata;
	logic          link_we;
	logic [LW-1:0] link_rdata;
	logic [LW-1:0] link_val;
	logic          alloc, release_en;
	logic          emit;
	result_t       res;

	assign pool_full = (free_top_q == LW'(SLOTS));
	assign top_idx   = pool_full ? '0 : free_top_q[SW-1:0];
	assign link_val  = link_vld_q[top_idx] ? link_rdata : LW'(top_idx) + LW'(1);

	// Associative search; the lowest matching active slot wins.
	always_comb begin
		cam_hit = 1'b0;
		cam_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (active_q[i] && cam_q[i] == cur_s1.call_id) begin
				cam_hit = 1'b1;
				cam_idx = SW'(i);
			end
		end
	end

	assign exp_in  = int'(cur_s1.slot) < SLOTS;
	assign exp_idx = exp_in ? SW'(cur_s1.slot) : '0;

	always_comb begin
		look_sel = cam_idx;
		look_hit = cam_hit;
		if (cur_s1.op == OP_DISPATCH) begin
			look_sel = top_idx;
			look_hit = 1'b0;
		end else if (cur_s1.op == OP_EXPIRE) begin
			look_sel = exp_idx;
			look_hit = exp_in && active_q[exp_idx];
		end
	end

	cct_ram #(.WIDTH(RW), .DEPTH(SLOTS)) u_slot_ram (
		.clk   (clk),
		.we    (rec_we),
		.waddr (sel_s2),
		.wdata (upd),
		.raddr (look_sel),
		.rdata (rec_rdata)
	);

	cct_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (sel_s2),
		.wdata (free_top_q),
		.raddr (top_idx),
		.rdata (link_rdata)
	);

	assign rec = slot_rec_t'(rec_rdata);

	always_comb begin
		unique case (state_q)
			BK_IDLE: state_d = q_empty ? BK_IDLE : BK_LOOK;
			BK_LOOK: state_d = BK_EXEC;
			BK_EXEC: state_d = q_empty ? BK_IDLE : BK_LOOK;
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop     = 1'b0;
		exec_en = 1'b0;
		unique case (state_q)
			BK_IDLE: pop = !q_empty;
			BK_LOOK: pop = 1'b0;
			BK_EXEC: begin
				pop     = !q_empty;
				exec_en = 1'b1;
			end
			default: pop = 1'b0;
		endcase
	end

	// Slot update and result for the command in execution.
	always_comb begin
		upd        = rec;
		rec_we     = 1'b0;
		alloc      = 1'b0;
		release_en = 1'b0;
		emit       = 1'b0;
		free_top_d = free_top_q;
		res                 = '0;
		res.result_kind     = RK_HANGUP;
		res.out_call_id     = rec.call_id;
		res.out_tag         = rec.tag;
		res.out_slot        = 6'(sel_s2);
		case (cur_s1.op)
			OP_DISPATCH: begin
				res.out_call_id = cur_s1.call_id;
				res.out_tag     = cur_s1.tag;
				emit            = 1'b1;
				if (pool_full || !cur_s1.make_ok) begin
					res.result_kind  = RK_REPORT;
					res.out_slot     = '0;
					res.outcome      = OC_NET_DOWN;
					res.final_status = ST_SVC_DOWN;
				end else begin
					res.result_kind = RK_ACCEPT;
					alloc           = 1'b1;
					rec_we          = 1'b1;
					upd.call_id     = cur_s1.call_id;
					upd.tag         = cur_s1.tag;
					upd.start       = cur_s1.time_ms;
					upd.ringing     = 1'b0;
					upd.cancelled   = 1'b0;
					upd.timer       = TMR_MAIN;
					free_top_d      = link_val;
				end
			end
			OP_RING: begin
				rec_we      = hit_s2;
				upd.ringing = 1'b1;
				upd.timer   = TMR_RING;
			end
			OP_DISARM: begin
				rec_we    = hit_s2;
				upd.timer = TMR_NONE;
			end
			OP_CONFIRM: emit = hit_s2;
			OP_DISCONNECT: begin
				emit             = hit_s2;
				release_en       = hit_s2;
				res.result_kind  = RK_REPORT;
				res.outcome      = outcome_of(rec.ringing, rec.cancelled, cur_s1.status);
				res.final_status = cur_s1.status;
				res.elapsed_ms   = cur_s1.time_ms - rec.start;
				if (hit_s2) free_top_d = LW'(sel_s2);
			end
			OP_FORWARD: begin
				rec_we    = hit_s2;
				emit      = hit_s2;
				upd.timer = TMR_NONE;
			end
			OP_PRACK_OK: begin
				if (hit_s2 && rec.ringing && !rec.cancelled) begin
					rec_we        = 1'b1;
					emit          = 1'b1;
					upd.cancelled = 1'b1;
					upd.timer     = TMR_NONE;
				end
			end
			OP_EXPIRE: begin
				// An expiry of a timer that is not armed is ignored.
				if (hit_s2 && rec.timer == (cur_s1.which ? TMR_RING : TMR_MAIN)) begin
					rec_we    = 1'b1;
					upd.timer = TMR_NONE;
					if (!(cur_s1.which && rec.cancelled)) begin
						upd.cancelled = 1'b1;
						emit          = 1'b1;
					end
				end
			end
			default: emit = 1'b0;
		endcase
		if (!exec_en) begin
			rec_we     = 1'b0;
			alloc      = 1'b0;
			release_en = 1'b0;
			emit       = 1'b0;
			free_top_d = free_top_q;
		end
	end

	assign link_we = release_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_IDLE;
			active_q   <= '0;
			link_vld_q <= '0;
			free_top_q <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q    <= state_d;
			free_top_q <= free_top_d;
			done_q     <= emit;
			if (alloc) active_q[sel_s2] <= 1'b1;
			if (release_en) begin
				active_q[sel_s2]   <= 1'b0;
				link_vld_q[sel_s2] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cur_s1 <= q_data;
		if (state_q == BK_LOOK) begin
			sel_s2 <= look_sel;
			hit_s2 <= look_hit;
		end
		if (alloc) cam_q[sel_s2] <= cur_s1.call_id;
		if (emit) result_q <= res;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== src/cct_checker.sv =====
// Port-level checks of the call context outcome tracker, bound to its top.
// Depends on cct_pkg and on the top level it is bound to.
module cct_checker import cct_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input logic    done,
	input result_t result
);

	// The queue can only fill through an item taken in the cycle before.
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without an item taken");

	// The back end looks up a slot before each result that it gives.
	a_done_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("results on two consecutive cycles");

	a_plain_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.result_kind == RK_ACCEPT || result.result_kind == RK_HANGUP)
		|-> result.outcome == '0 && result.final_status == '0
			&& result.elapsed_ms == '0)
		else $error("accept or hangup result carries report fields");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.result_kind == RK_ACCEPT |-> int'(result.out_slot) < SLOTS)
		else $error("call accepted into a slot outside the pool");

endmodule

bind call_context_outcome_tracker cct_checker #(.SLOTS(SLOTS)) u_cct_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
